>>> sv/balm_pkg.sv
// Shared types and constants of the bit angle LED modulator.
package balm_pkg;

   // Fixed field widths
   localparam int NUM_PORTS = 3;
   localparam int PORT_W    = 2;
   localparam int PIN_W     = 3;
   localparam int DUTY_W    = 8;
   localparam int DRIVE_W   = 8;
   localparam int SLICE_W   = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 8;

   // Item kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PORT_B_MASK = 2'd0,
      CSR_PORT_C_MASK = 2'd1,
      CSR_PORT_D_MASK = 2'd2,
      CSR_INVERT      = 2'd3
   } csr_index_type;

   // One bit plane of drive bits, one byte per port
   typedef logic [NUM_PORTS-1:0][DRIVE_W-1:0] plane_type;

   // Slice timer status handed to the top level
   typedef struct packed {
      logic               change;     // slice moves on with this tick
      logic [SLICE_W-1:0] slice_next; // slice shown after this item
      logic               cycle_end;  // new slice is the last one
   } slice_event_type;

endpackage

>>> sv/balm_duty_store.sv
// Duty value registers for all LEDs and the bit plane selection for a slice.
module balm_duty_store #(
   parameter int DUTY_BITS = 8,
   parameter int PORT_PINS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_en,
   input  logic [balm_pkg::PORT_W-1:0]        wr_port,
   input  logic [balm_pkg::PIN_W-1:0]         wr_pin,
   input  logic [balm_pkg::DUTY_W-1:0]        wr_duty,
   input  logic [$clog2(DUTY_BITS)-1:0]       plane_sel,
   output balm_pkg::plane_type                plane
);
   import balm_pkg::*;

   // Only the shown duty bits are kept
   logic [DUTY_BITS-1:0] duty_ff [NUM_PORTS][PORT_PINS];

   // Per-entry write decode; port three and absent pins match no entry
   always_ff @(posedge clock) begin
      for (int p = 0; p < NUM_PORTS; p++) begin
         for (int q = 0; q < PORT_PINS; q++) begin
            if (reset) begin
               duty_ff[p][q] <= '0;
            end else if (wr_en && wr_port == PORT_W'(p) && wr_pin == PIN_W'(q)) begin
               duty_ff[p][q] <= wr_duty[DUTY_BITS-1:0];
            end
         end
      end
   end

   // Bit plane of the selected slice; absent pins read 0
   always_comb begin
      plane = '0;
      for (int p = 0; p < NUM_PORTS; p++) begin
         for (int q = 0; q < PORT_PINS; q++) begin
            plane[p][q] = duty_ff[p][q][plane_sel];
         end
      end
   end

endmodule

>>> sv/balm_slice_timer.sv
// Tick counter and slice index: slice k lasts 2^k ticks.
module balm_slice_timer #(
   parameter int DUTY_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      tick_en,
   output balm_pkg::slice_event_type slice_event
);
   import balm_pkg::*;

   localparam int TICK_W = DUTY_BITS - 1;
   localparam logic [SLICE_W-1:0] LAST_SLICE = SLICE_W'(DUTY_BITS - 1);

   logic [TICK_W-1:0]  ticks_ff, ticks_in;
   logic [SLICE_W-1:0] slice_ff, slice_in;
   logic [TICK_W:0]    ticks_inc;
   logic [TICK_W:0]    slice_len;
   logic               wrap;

   // Slice length and end-of-slice detect
   assign ticks_inc = {1'b0, ticks_ff} + (TICK_W+1)'(1);
   assign slice_len = (TICK_W+1)'(1) << slice_ff;
   assign wrap      = tick_en && (ticks_inc >= slice_len);

   // Next counter and slice
   always_comb begin
      ticks_in = ticks_ff;
      slice_in = slice_ff;
      if (wrap) begin
         ticks_in = '0;
         slice_in = (slice_ff >= LAST_SLICE) ? '0 : slice_ff + SLICE_W'(1);
      end else if (tick_en) begin
         ticks_in = ticks_inc[TICK_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= '0;
         slice_ff <= '0;
      end else begin
         ticks_ff <= ticks_in;
         slice_ff <= slice_in;
      end
   end

   assign slice_event.change     = wrap;
   assign slice_event.slice_next = slice_in;
   assign slice_event.cycle_end  = wrap && (slice_in == LAST_SLICE);

endmodule

>>> sv/bit_angle_led_modulator.sv
// Top level of the bit angle LED modulator: handshakes, port drive latches and CSRs.
//
// Binary code modulation driver for three 8-pin LED ports. Each request is either a
// duty write for one LED (port, pin) or one timer tick; every request gives exactly one
// response with the drive bits of all three ports, the slice now shown and a cycle-end
// flag. Requests are taken one per clock with no gaps while responses are not stalled;
// a request passes an input register and then an output register, which holds its
// response until taken. The rate is set by the update of the tick counter and the
// drive latches, which read all duty registers of the new slice's bit plane at once.
// Mask and polarity writes act at the next slice change.
module bit_angle_led_modulator #(
   parameter int DUTY_BITS = 8,
   parameter int PORT_PINS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_kind,
   input  logic [balm_pkg::PORT_W-1:0]        req_port,
   input  logic [balm_pkg::PIN_W-1:0]         req_pin,
   input  logic [balm_pkg::DUTY_W-1:0]        req_duty,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [balm_pkg::DRIVE_W-1:0]       rsp_drive_b,
   output logic [balm_pkg::DRIVE_W-1:0]       rsp_drive_c,
   output logic [balm_pkg::DRIVE_W-1:0]       rsp_drive_d,
   output logic [balm_pkg::SLICE_W-1:0]       rsp_slice_index,
   output logic                               rsp_cycle_end,
   // configuration write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [balm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [balm_pkg::CSR_DAT_W-1:0]     csr_data
);
   import balm_pkg::*;

   localparam int SEL_W = $clog2(DUTY_BITS);

   // Input register
   logic               in_valid_ff, in_valid_in;
   logic               kind_ff;
   logic [PORT_W-1:0]  port_ff;
   logic [PIN_W-1:0]   pin_ff;
   logic [DUTY_W-1:0]  duty_ff;

   // Output register
   logic               out_valid_ff, out_valid_in;
   logic [DRIVE_W-1:0] out_b_ff, out_c_ff, out_d_ff;
   logic [SLICE_W-1:0] out_slice_ff;
   logic               out_cend_ff;

   // Port drive latches and configuration
   plane_type          drive_ff, drive_in;
   logic [DRIVE_W-1:0] mask_b_ff, mask_c_ff, mask_d_ff;
   logic               invert_ff;

   logic               req_take;
   logic               advance;
   slice_event_type    slice_event;
   plane_type          plane;
   plane_type          mask;

   // Handshake control
   assign advance      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign req_take     = req_valid && !req_stall;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);
   assign csr_ready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Request payload capture
   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff <= req_kind;
         port_ff <= req_port;
         pin_ff  <= req_pin;
         duty_ff <= req_duty;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_b_ff <= '0;
         mask_c_ff <= '0;
         mask_d_ff <= '0;
         invert_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_PORT_B_MASK: mask_b_ff <= csr_data;
            CSR_PORT_C_MASK: mask_c_ff <= csr_data;
            CSR_PORT_D_MASK: mask_d_ff <= csr_data;
            CSR_INVERT:      invert_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   balm_duty_store #(
      .DUTY_BITS (DUTY_BITS),
      .PORT_PINS (PORT_PINS)
   ) u_duty_store (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (advance && kind_ff == KIND_WRITE),
      .wr_port   (port_ff),
      .wr_pin    (pin_ff),
      .wr_duty   (duty_ff),
      .plane_sel (slice_event.slice_next[SEL_W-1:0]),
      .plane     (plane)
   );

   balm_slice_timer #(
      .DUTY_BITS (DUTY_BITS)
   ) u_slice_timer (
      .clock       (clock),
      .reset       (reset),
      .tick_en     (advance && kind_ff == KIND_TICK),
      .slice_event (slice_event)
   );

   // Drive latch: plane XOR polarity, gated by the LED mask and absent pins
   always_comb begin
      mask[0] = mask_b_ff;
      mask[1] = mask_c_ff;
      mask[2] = mask_d_ff;
      drive_in = drive_ff;
      if (slice_event.change) begin
         for (int p = 0; p < NUM_PORTS; p++) begin
            drive_in[p] = '0;
            for (int q = 0; q < PORT_PINS; q++) begin
               drive_in[p][q] = (plane[p][q] ^ invert_ff) & mask[p][q];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff <= '0;
      end else begin
         drive_ff <= drive_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (advance) begin
         out_b_ff     <= drive_in[0];
         out_c_ff     <= drive_in[1];
         out_d_ff     <= drive_in[2];
         out_slice_ff <= slice_event.slice_next;
         out_cend_ff  <= slice_event.cycle_end;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_drive_b     = out_b_ff;
   assign rsp_drive_c     = out_c_ff;
   assign rsp_drive_d     = out_d_ff;
   assign rsp_slice_index = out_slice_ff;
   assign rsp_cycle_end   = out_cend_ff;

endmodule

>>> bench/tb_bit_angle_led_modulator.sv
// Testbench for the bit angle LED modulator: scripted and random transfers, predictor checked.
`timescale 1ns / 1ps

module tb_bit_angle_led_modulator;
   import balm_pkg::*;

   localparam int LED_DUTY_BITS = 8;
   localparam int LED_PINS      = 8;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_B_ROW   = 15;
   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_ITEMS   = 100;

   // Port numbers as carried in a duty write
   localparam logic [PORT_W-1:0] PORT_B    = 2'd0;
   localparam logic [PORT_W-1:0] PORT_C    = 2'd1;
   localparam logic [PORT_W-1:0] PORT_D    = 2'd2;
   localparam logic [PORT_W-1:0] PORT_NONE = 2'd3;

   typedef struct packed {
      logic [DRIVE_W-1:0] drive_b;
      logic [DRIVE_W-1:0] drive_c;
      logic [DRIVE_W-1:0] drive_d;
      logic [SLICE_W-1:0] slice;
      logic               cycle_end;
   } led_result_type;

   typedef struct {
      logic              kind;
      logic [PORT_W-1:0] port;
      logic [PIN_W-1:0]  pin;
      logic [DUTY_W-1:0] duty;
      bit                typed;
      led_result_type    result;
   } script_row_type;

   // All ports dark, first slice, no cycle end: shown before the first slice change
   localparam led_result_type ALL_DARK = '0;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_kind  = KIND_WRITE;
   logic [PORT_W-1:0]    req_port  = '0;
   logic [PIN_W-1:0]     req_pin   = '0;
   logic [DUTY_W-1:0]    req_duty  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [DRIVE_W-1:0]   rsp_drive_b;
   logic [DRIVE_W-1:0]   rsp_drive_c;
   logic [DRIVE_W-1:0]   rsp_drive_d;
   logic [SLICE_W-1:0]   rsp_slice_index;
   logic                 rsp_cycle_end;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   csr_index_type        csr_index = CSR_PORT_B_MASK;
   logic [CSR_DAT_W-1:0] csr_data  = '0;

   // Predictor state: duty values, slice timer, latched drive and register copies
   logic [DUTY_W-1:0]    duty_mem [NUM_PORTS*8];
   plane_type            port_drive;
   logic [SLICE_W-1:0]   shown_slice;
   int                   ticks_in_slice;
   logic [DRIVE_W-1:0]   mask_cfg [NUM_PORTS];
   logic                 invert_cfg;

   led_result_type       led_expect_q[$];
   script_row_type       led_script[$];
   int                   mismatch_count = 0;
   int                   cycle_count    = 0;
   int                   stall_left     = 0;
   bit                   calm           = 1'b0;

   bit_angle_led_modulator #(
      .DUTY_BITS (LED_DUTY_BITS),
      .PORT_PINS (LED_PINS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_port        (req_port),
      .req_pin         (req_pin),
      .req_duty        (req_duty),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_drive_b     (rsp_drive_b),
      .rsp_drive_c     (rsp_drive_c),
      .rsp_drive_d     (rsp_drive_d),
      .rsp_slice_index (rsp_slice_index),
      .rsp_cycle_end   (rsp_cycle_end),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short idle runs, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] pick_mask();
      case ($urandom_range(0, 3))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Advance the predictor by one item and return the drive shown afterwards
   function automatic led_result_type predict_led_drive(logic kind, logic [PORT_W-1:0] port,
                                                        logic [PIN_W-1:0] pin,
                                                        logic [DUTY_W-1:0] duty);
      led_result_type res;
      logic           lit;
      res = '0;
      if (kind == KIND_WRITE) begin
         // port three and pins beyond the port width are dropped
         if (port < NUM_PORTS && pin < LED_PINS) duty_mem[port*8 + pin] = duty;
      end else if (ticks_in_slice + 1 >= (1 << shown_slice)) begin
         // slice change: move on, wrap after the top bit, relatch every port
         ticks_in_slice = 0;
         shown_slice = (shown_slice >= LED_DUTY_BITS - 1) ? '0 : shown_slice + 1'b1;
         for (int p = 0; p < NUM_PORTS; p++) begin
            for (int q = 0; q < 8; q++) begin
               lit = duty_mem[p*8 + q][shown_slice] ^ invert_cfg;
               port_drive[p][q] = lit & mask_cfg[p][q] & (q < LED_PINS);
            end
         end
         res.cycle_end = (shown_slice == LED_DUTY_BITS - 1);
      end else begin
         ticks_in_slice++;
      end
      res.drive_b = port_drive[0];
      res.drive_c = port_drive[1];
      res.drive_d = port_drive[2];
      res.slice   = shown_slice;
      return res;
   endfunction

   task automatic add_row(logic kind, logic [PORT_W-1:0] port, logic [PIN_W-1:0] pin,
                          logic [DUTY_W-1:0] duty, bit typed, led_result_type result);
      script_row_type row;
      row.kind   = kind;
      row.port   = port;
      row.pin    = pin;
      row.duty   = duty;
      row.typed  = typed;
      row.result = result;
      led_script.push_back(row);
   endtask

   // One request transfer, after a random gap; the expectation is queued on acceptance
   task automatic send_item(logic kind, logic [PORT_W-1:0] port, logic [PIN_W-1:0] pin,
                            logic [DUTY_W-1:0] duty, bit typed,
                            led_result_type typed_result);
      int             gap;
      led_result_type predicted;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_port  <= port;
      req_pin   <= pin;
      req_duty  <= duty;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_led_drive(kind, port, pin, duty);
      led_expect_q.push_back(typed ? typed_result : predicted);
   endtask

   task automatic write_csr(csr_index_type index, logic [CSR_DAT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_PORT_B_MASK: mask_cfg[0] = data;
         CSR_PORT_C_MASK: mask_cfg[1] = data;
         CSR_PORT_D_MASK: mask_cfg[2] = data;
         CSR_INVERT:      invert_cfg  = data[0];
      endcase
   endtask

   // Writes all four registers; spare bits of the polarity write are random
   task automatic apply_settings(logic [7:0] b_mask, logic [7:0] c_mask, logic [7:0] d_mask,
                                 logic invert);
      write_csr(CSR_PORT_B_MASK, b_mask);
      write_csr(CSR_PORT_C_MASK, c_mask);
      write_csr(CSR_PORT_D_MASK, d_mask);
      write_csr(CSR_INVERT, {7'($urandom_range(0, 127)), invert});
      csr_valid <= 1'b0;
   endtask

   // Let every expected result arrive
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (led_expect_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Response check and random stall
   always @(posedge clock) begin : rsp_check
      led_result_type want;
      led_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.drive_b   = rsp_drive_b;
         got.drive_c   = rsp_drive_c;
         got.drive_d   = rsp_drive_d;
         got.slice     = rsp_slice_index;
         got.cycle_end = rsp_cycle_end;
         if (led_expect_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected transfer: b=%h c=%h d=%h slice=%0d end=%b",
                        got.drive_b, got.drive_c, got.drive_d, got.slice, got.cycle_end);
         end else begin
            want = led_expect_q.pop_front();
            if (got.drive_b !== want.drive_b || got.drive_c !== want.drive_c ||
                got.drive_d !== want.drive_d || got.slice !== want.slice ||
                got.cycle_end !== want.cycle_end) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected b=%h c=%h d=%h slice=%0d end=%b, %s",
                           want.drive_b, want.drive_c, want.drive_d, want.slice,
                           want.cycle_end,
                           $sformatf("got b=%h c=%h d=%h slice=%0d end=%b",
                                     got.drive_b, got.drive_c, got.drive_d, got.slice,
                                     got.cycle_end));
            end
         end
      end
      if (calm || stall_left == 0) begin
         rsp_stall <= 1'b0;
         stall_left = calm ? 0 : pick_gap();
      end else begin
         rsp_stall <= 1'b1;
         stall_left--;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin : stimulus
      logic              kind;
      logic [PORT_W-1:0] port;
      logic [DUTY_W-1:0] duty;
      int                r;

      // predictor at its reset state
      foreach (duty_mem[i]) duty_mem[i] = '0;
      foreach (mask_cfg[i]) mask_cfg[i] = '0;
      port_drive     = '0;
      shown_slice    = '0;
      ticks_in_slice = 0;
      invert_cfg     = 1'b0;

      // Script, first part: all pins masked in, inverted; writes before any slice change stay dark
      add_row(KIND_WRITE, PORT_B,    3'd0, 8'hFF, 1'b1, ALL_DARK);
      add_row(KIND_WRITE, PORT_D,    3'd7, 8'h00, 1'b1, ALL_DARK);
      add_row(KIND_WRITE, PORT_NONE, 3'd2, 8'hAA, 1'b1, ALL_DARK);
      add_row(KIND_WRITE, PORT_C,    3'd4, 8'h5A, 1'b1, ALL_DARK);
      add_row(KIND_WRITE, PORT_B,    3'd7, 8'h80, 1'b1, ALL_DARK);
      add_row(KIND_WRITE, PORT_C,    3'd0, 8'h01, 1'b1, ALL_DARK);
      add_row(KIND_WRITE, PORT_D,    3'd3, 8'hFF, 1'b1, ALL_DARK);
      repeat (8) add_row(KIND_TICK, PORT_NONE, 3'd7, 8'hFF, 1'b0, ALL_DARK);
      // second part: partial masks, normal polarity, writes to masked-out pins
      add_row(KIND_WRITE, PORT_D, 3'd0, 8'h81, 1'b0, ALL_DARK);
      add_row(KIND_WRITE, PORT_B, 3'd1, 8'hFF, 1'b0, ALL_DARK);
      repeat (8) add_row(KIND_TICK, PORT_B, 3'd0, 8'h00, 1'b0, ALL_DARK);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      apply_settings(8'hFF, 8'hFF, 8'hFF, 1'b1);
      for (int i = 0; i < led_script.size(); i++) begin
         if (i == PHASE_B_ROW) begin
            wait_idle();
            apply_settings(8'h00, 8'hA5, 8'hFF, 1'b0);
         end
         send_item(led_script[i].kind, led_script[i].port, led_script[i].pin,
                   led_script[i].duty, led_script[i].typed, led_script[i].result);
      end

      // Random phases: mostly ticks so that slices wrap, with duty writes mixed in
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_idle();
         case (ph)
            0:       apply_settings(8'h00, 8'h00, 8'h00, 1'b1);
            1:       apply_settings(8'hFF, 8'hFF, 8'hFF, 1'b0);
            default: apply_settings(pick_mask(), pick_mask(), pick_mask(),
                                    1'($urandom_range(0, 1)));
         endcase
         calm = (ph == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r    = $urandom_range(0, 99);
            kind = (r < 80) ? KIND_TICK : KIND_WRITE;
            if (kind == KIND_TICK || $urandom_range(0, 11) == 0)
               port = 2'($urandom_range(0, 3));
            else
               port = 2'($urandom_range(0, 2));
            case ($urandom_range(0, 4))
               0:       duty = 8'h00;
               1:       duty = 8'hFF;
               default: duty = 8'($urandom);
            endcase
            send_item(kind, port, 3'($urandom_range(0, 7)), duty, 1'b0, ALL_DARK);
         end
      end
      calm = 1'b0;

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && led_expect_q.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
